// File: src/sdf8_pkg.sv
// Package: constants, types and helpers for the signed distance field core.
`timescale 1ns / 1ps
package sdf8_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int DIM_W  = 9;            // width of the dimension registers
    localparam int OFS_W  = 12;           // one signed offset component
    localparam int LEN_W  = 2 * OFS_W;    // squared length
    localparam int WORD_W = 4 * OFS_W;    // near dx, near dy, far dx, far dy

    localparam logic [1:0] CFG_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_HEIGHT    = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;
    localparam logic [1:0] CFG_GAIN      = 2'd3;

    localparam logic [1:0] MODE_LOAD      = 2'd0;
    localparam logic [1:0] MODE_TRANSFORM = 2'd1;
    localparam logic [1:0] MODE_READ      = 2'd2;

    typedef struct packed {
        logic signed [1:0] dx;
        logic signed [1:0] dy;
    } nb_ofs_t;

    // Neighbor offsets of each sweep: forward row, backward row,
    // backward row of the upward pass, forward row of the upward pass.
    function automatic nb_ofs_t nb_ofs(input logic [1:0] phase, input logic [1:0] k);
        nb_ofs_t o;
        o.dx = 2'sd0;
        o.dy = 2'sd0;
        case (phase)
            2'd0: begin
                case (k)
                    2'd0: begin o.dx = -2'sd1; o.dy = 2'sd0;  end
                    2'd1: begin o.dx = 2'sd0;  o.dy = -2'sd1; end
                    2'd2: begin o.dx = -2'sd1; o.dy = -2'sd1; end
                    default: begin o.dx = 2'sd1; o.dy = -2'sd1; end
                endcase
            end
            2'd1: begin o.dx = 2'sd1; o.dy = 2'sd0; end
            2'd2: begin
                case (k)
                    2'd0: begin o.dx = 2'sd1;  o.dy = 2'sd0; end
                    2'd1: begin o.dx = 2'sd0;  o.dy = 2'sd1; end
                    2'd2: begin o.dx = -2'sd1; o.dy = 2'sd1; end
                    default: begin o.dx = 2'sd1; o.dy = 2'sd1; end
                endcase
            end
            default: begin o.dx = -2'sd1; o.dy = 2'sd0; end
        endcase
        return o;
    endfunction

endpackage

// File: src/sdf8_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sdf8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/signed_distance_field_8ssedt_core.sv
// Top level: 8SSEDT signed distance field core with shared multiplier and sqrt.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_mode, s_column, s_line, s_pixel
//  m_      | out       | m_valid / m_ready  | m_distance_value, m_status
//  cfg_    | in        | cfg_we             | cfg_index, cfg_data
//
// Load: one RAM write. Read: two squared lengths on the one
// multiplier, two 12-step square roots, one gain multiply.
// Transform: each pixel visit reads its own word and squares its length, then per
// neighbor a read (skipped out of bounds), the multiplier states and a compare;
// every pixel gets four visits with ten neighbors per grid, over both grids.
// Reset is synchronous; grid RAM is not cleared. A finished item waits in the
// output register while the next item is accepted.
`timescale 1ns / 1ps
module signed_distance_field_8ssedt_core
    import sdf8_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_mode,
    input  logic [7:0]       s_column,
    input  logic [7:0]       s_line,
    input  logic [7:0]       s_pixel,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_distance_value,
    output logic             m_status,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [DIM_W-1:0] cfg_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_OUT    = 4'd1;
    localparam logic [3:0] ST_T_CEN  = 4'd2;
    localparam logic [3:0] ST_T_CEND = 4'd3;
    localparam logic [3:0] ST_T_PL   = 4'd4;
    localparam logic [3:0] ST_T_NB   = 4'd5;
    localparam logic [3:0] ST_T_NBD  = 4'd6;
    localparam logic [3:0] ST_T_CMP  = 4'd7;
    localparam logic [3:0] ST_T_WR   = 4'd8;
    localparam logic [3:0] ST_L0     = 4'd9;
    localparam logic [3:0] ST_L1     = 4'd10;
    localparam logic [3:0] ST_L2     = 4'd11;
    localparam logic [3:0] ST_R_D    = 4'd12;
    localparam logic [3:0] ST_SQ     = 4'd13;
    localparam logic [3:0] ST_G0     = 4'd14;
    localparam logic [3:0] ST_G1     = 4'd15;

    typedef logic signed [OFS_W-1:0] ofs_t;

    function automatic logic [ADDR_W-1:0] grid_addr(input logic [DIM_W-1:0] c,
                                                    input logic [DIM_W-1:0] r);
        return ADDR_W'(32'(r) * MAX_WIDTH + 32'(c));
    endfunction

    // configuration
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [7:0]       threshold_reg;
    logic [3:0]       gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= DIM_W'(256);
            height_reg    <= DIM_W'(256);
            threshold_reg <= 8'd128;
            gain_reg      <= 4'd3;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_WIDTH:     width_reg     <= cfg_data;
                CFG_HEIGHT:    height_reg    <= cfg_data;
                CFG_THRESHOLD: threshold_reg <= cfg_data[7:0];
                CFG_GAIN:      gain_reg      <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] eff_w, eff_h;
    assign eff_w = (32'(width_reg) < MAX_WIDTH) ? width_reg : DIM_W'(MAX_WIDTH);
    assign eff_h = (32'(height_reg) < MAX_HEIGHT) ? height_reg : DIM_W'(MAX_HEIGHT);

    // state
    logic [3:0]        state_reg, state_next;
    logic [3:0]        ret_reg, ret_next;
    logic [DIM_W-1:0]  c_reg, c_next, r_reg, r_next;
    logic [1:0]        phase_reg, phase_next, k_reg, k_next;
    logic              grid_reg, grid_next, sq_sel_reg, sq_sel_next;
    logic [WORD_W-1:0] word_reg, word_next;
    ofs_t              p_dx_reg, p_dx_next, p_dy_reg, p_dy_next;
    ofs_t              opr_dx_reg, opr_dx_next, opr_dy_reg, opr_dy_next;
    logic [LEN_W-1:0]  plen_reg, plen_next, len_reg, len_next, acc_reg, acc_next;
    logic [LEN_W-1:0]  sq_v_reg, sq_v_next, sq_res_reg, sq_res_next;
    logic [LEN_W-1:0]  sq_bit_reg, sq_bit_next;
    ofs_t              sn_reg, sn_next, diff_reg, diff_next;
    logic signed [LEN_W-1:0] mul_reg;
    ofs_t              mul_a, mul_b;
    logic [7:0]        pend_val_reg, pend_val_next;
    logic              pend_st_reg, pend_st_next;
    logic              m_valid_reg;
    logic [7:0]        m_val_reg;
    logic              m_st_reg;

    // RAM
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    sdf8_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_grid (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared multiplier, registered
    always_comb begin
        mul_a = diff_reg;
        mul_b = ofs_t'({{(OFS_W-4){1'b0}}, gain_reg});
        if (state_reg == ST_L0) begin
            mul_a = opr_dx_reg;
            mul_b = opr_dx_reg;
        end else if (state_reg == ST_L1) begin
            mul_a = opr_dy_reg;
            mul_b = opr_dy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
    end

    logic                    in_inside;
    nb_ofs_t                 nb;
    logic signed [DIM_W+1:0] nc, nr;
    logic                    nb_out, nb_last;
    ofs_t                    r_dx, r_dy;
    logic [LEN_W-1:0]        sq_trial;
    logic signed [LEN_W-1:0] gval;
    logic [ADDR_W-1:0]       here_addr;

    assign in_inside = ({1'b0, s_column} < eff_w) && ({1'b0, s_line} < eff_h);
    assign nb        = nb_ofs(phase_reg, k_reg);
    assign nc        = $signed({2'b00, c_reg}) + (DIM_W+2)'(nb.dx);
    assign nr        = $signed({2'b00, r_reg}) + (DIM_W+2)'(nb.dy);
    assign nb_out    = nc < 0 || nr < 0 || nc >= $signed({2'b00, eff_w})
                       || nr >= $signed({2'b00, eff_h});
    assign nb_last   = phase_reg[0] || k_reg == 2'd3;
    assign here_addr = grid_addr(c_reg, r_reg);
    // selected grid half of fresh RAM data
    assign r_dx      = grid_reg ? ram_rdata[2*OFS_W-1:OFS_W] : ram_rdata[4*OFS_W-1:3*OFS_W];
    assign r_dy      = grid_reg ? ram_rdata[OFS_W-1:0]       : ram_rdata[3*OFS_W-1:2*OFS_W];
    assign sq_trial  = sq_res_reg + sq_bit_reg;
    assign gval      = mul_reg + LEN_W'(128);

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        c_next        = c_reg;
        r_next        = r_reg;
        phase_next    = phase_reg;
        k_next        = k_reg;
        grid_next     = grid_reg;
        sq_sel_next   = sq_sel_reg;
        word_next     = word_reg;
        p_dx_next     = p_dx_reg;
        p_dy_next     = p_dy_reg;
        opr_dx_next   = opr_dx_reg;
        opr_dy_next   = opr_dy_reg;
        plen_next     = plen_reg;
        len_next      = len_reg;
        acc_next      = acc_reg;
        sq_v_next     = sq_v_reg;
        sq_res_next   = sq_res_reg;
        sq_bit_next   = sq_bit_reg;
        sn_next       = sn_reg;
        diff_next     = diff_reg;
        pend_val_next = pend_val_reg;
        pend_st_next  = pend_st_reg;
        ram_we        = 1'b0;
        ram_waddr     = here_addr;
        ram_wdata     = word_reg;
        ram_raddr     = here_addr;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    pend_val_next = 8'd0;
                    pend_st_next  = 1'b0;
                    state_next    = ST_OUT;
                    if (s_mode == MODE_LOAD || s_mode == MODE_READ) begin
                        pend_st_next = !in_inside;
                        ram_raddr    = grid_addr({1'b0, s_column}, {1'b0, s_line});
                        ram_waddr    = ram_raddr;
                        if (in_inside && s_mode == MODE_LOAD) begin
                            ram_we = 1'b1;
                            if (s_pixel < threshold_reg) begin
                                ram_wdata = {OFS_W'(0), OFS_W'(0), OFS_W'(eff_w), OFS_W'(eff_h)};
                            end else begin
                                ram_wdata = {OFS_W'(eff_w), OFS_W'(eff_h), OFS_W'(0), OFS_W'(0)};
                            end
                        end else if (in_inside) begin
                            state_next = ST_R_D;
                        end
                    end else if (s_mode == MODE_TRANSFORM) begin
                        c_next     = '0;
                        r_next     = '0;
                        phase_next = 2'd0;
                        grid_next  = 1'b0;
                        if (eff_w != '0 && eff_h != '0) begin
                            state_next = ST_T_CEN;
                        end
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_T_CEN: begin
                state_next = ST_T_CEND;
            end
            ST_T_CEND: begin
                word_next   = ram_rdata;
                p_dx_next   = r_dx;
                p_dy_next   = r_dy;
                opr_dx_next = r_dx;
                opr_dy_next = r_dy;
                ret_next    = ST_T_PL;
                state_next  = ST_L0;
            end
            ST_T_PL: begin
                plen_next  = len_reg;
                k_next     = 2'd0;
                state_next = ST_T_NB;
            end
            ST_T_NB: begin
                ram_raddr = grid_addr(nc[DIM_W-1:0], nr[DIM_W-1:0]);
                if (nb_out) begin
                    opr_dx_next = OFS_W'(eff_w) + OFS_W'(nb.dx);
                    opr_dy_next = OFS_W'(eff_h) + OFS_W'(nb.dy);
                    ret_next    = ST_T_CMP;
                    state_next  = ST_L0;
                end else begin
                    state_next = ST_T_NBD;
                end
            end
            ST_T_NBD: begin
                opr_dx_next = r_dx + OFS_W'(nb.dx);
                opr_dy_next = r_dy + OFS_W'(nb.dy);
                ret_next    = ST_T_CMP;
                state_next  = ST_L0;
            end
            ST_T_CMP: begin
                if (len_reg < plen_reg) begin
                    p_dx_next = opr_dx_reg;
                    p_dy_next = opr_dy_reg;
                    plen_next = len_reg;
                end
                if (nb_last) begin
                    state_next = ST_T_WR;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_T_NB;
                end
            end
            ST_T_WR: begin
                ram_we     = 1'b1;
                ram_wdata  = grid_reg ? {word_reg[4*OFS_W-1:2*OFS_W], p_dx_reg, p_dy_reg}
                                      : {p_dx_reg, p_dy_reg, word_reg[2*OFS_W-1:0]};
                state_next = ST_T_CEN;
                unique case (phase_reg)
                    2'd0: begin
                        if (c_reg == eff_w - 1'b1) phase_next = 2'd1;
                        else c_next = c_reg + 1'b1;
                    end
                    2'd1: begin
                        if (c_reg != '0) begin
                            c_next = c_reg - 1'b1;
                        end else if (r_reg == eff_h - 1'b1) begin
                            phase_next = 2'd2;
                            c_next     = eff_w - 1'b1;
                        end else begin
                            phase_next = 2'd0;
                            r_next     = r_reg + 1'b1;
                        end
                    end
                    2'd2: begin
                        if (c_reg == '0) phase_next = 2'd3;
                        else c_next = c_reg - 1'b1;
                    end
                    default: begin
                        if (c_reg != eff_w - 1'b1) begin
                            c_next = c_reg + 1'b1;
                        end else if (r_reg != '0) begin
                            phase_next = 2'd2;
                            r_next     = r_reg - 1'b1;
                            c_next     = eff_w - 1'b1;
                        end else if (!grid_reg) begin
                            grid_next  = 1'b1;
                            phase_next = 2'd0;
                            c_next     = '0;
                        end else begin
                            state_next = ST_OUT;
                        end
                    end
                endcase
            end
            ST_L0: begin
                state_next = ST_L1;
            end
            ST_L1: begin
                acc_next   = mul_reg;
                state_next = ST_L2;
            end
            ST_L2: begin
                len_next    = acc_reg + mul_reg;
                sq_v_next   = acc_reg + mul_reg;
                sq_res_next = '0;
                sq_bit_next = LEN_W'(1) << (LEN_W - 2);
                state_next  = ret_reg;
            end
            ST_R_D: begin
                word_next   = ram_rdata;
                opr_dx_next = ram_rdata[4*OFS_W-1:3*OFS_W];
                opr_dy_next = ram_rdata[3*OFS_W-1:2*OFS_W];
                sq_sel_next = 1'b0;
                ret_next    = ST_SQ;
                state_next  = ST_L0;
            end
            ST_SQ: begin
                if (sq_bit_reg != '0) begin
                    if (sq_v_reg >= sq_trial) begin
                        sq_v_next   = sq_v_reg - sq_trial;
                        sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                    end else begin
                        sq_res_next = sq_res_reg >> 1;
                    end
                    sq_bit_next = sq_bit_reg >> 2;
                end else if (!sq_sel_reg) begin
                    sn_next     = sq_res_reg[OFS_W-1:0];
                    sq_sel_next = 1'b1;
                    opr_dx_next = word_reg[2*OFS_W-1:OFS_W];
                    opr_dy_next = word_reg[OFS_W-1:0];
                    state_next  = ST_L0;
                end else begin
                    diff_next  = sn_reg - sq_res_reg[OFS_W-1:0];
                    state_next = ST_G0;
                end
            end
            ST_G0: begin
                state_next = ST_G1;
            end
            ST_G1: begin
                if (gval < 0) pend_val_next = 8'd0;
                else if (gval > LEN_W'(255)) pend_val_next = 8'd255;
                else pend_val_next = gval[7:0];
                state_next = ST_OUT;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ret_reg      <= ret_next;
        c_reg        <= c_next;
        r_reg        <= r_next;
        phase_reg    <= phase_next;
        k_reg        <= k_next;
        grid_reg     <= grid_next;
        sq_sel_reg   <= sq_sel_next;
        word_reg     <= word_next;
        p_dx_reg     <= p_dx_next;
        p_dy_reg     <= p_dy_next;
        opr_dx_reg   <= opr_dx_next;
        opr_dy_reg   <= opr_dy_next;
        plen_reg     <= plen_next;
        len_reg      <= len_next;
        acc_reg      <= acc_next;
        sq_v_reg     <= sq_v_next;
        sq_res_reg   <= sq_res_next;
        sq_bit_reg   <= sq_bit_next;
        sn_reg       <= sn_next;
        diff_reg     <= diff_next;
        pend_val_reg <= pend_val_next;
        pend_st_reg  <= pend_st_next;
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_val_reg <= pend_val_reg;
            m_st_reg  <= pend_st_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_distance_value = m_val_reg;
    assign m_status         = m_st_reg;

endmodule
